>>> design/tdm_pkg.sv
`timescale 1ns / 1ps

package tdm_pkg;

    typedef enum logic [1:0] {
        MODE_DEC   = 2'd0,
        MODE_BEAT  = 2'd1,
        MODE_HEX   = 2'd2,
        MODE_BLANK = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MODE       = 2'd0,
        CFG_GMT_OFFSET = 2'd1,
        CFG_DST_ENABLE = 2'd2
    } cfg_index_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int OFFSET_W    = 5;

    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int CHAR_W   = 7;

    localparam int NUM_STAGES = 7;

    localparam int HSEL_W    = 5;
    localparam int MINSEC_W  = 12;
    localparam int BLOCK_W   = 4;
    localparam int TOD_W     = 17;
    localparam int SHIFT_W   = 7;
    localparam int NUM_W     = 23;
    localparam int RECIP_W   = 26;
    localparam int PROD_W    = NUM_W + RECIP_W;
    localparam int DIV_SHIFT = 33;
    localparam int Q_W       = 14;
    localparam int HEX_W     = 16;

    localparam int Q10_W     = 11;
    localparam int Q100_W    = 8;
    localparam int Q1000_W   = 4;
    localparam int DRECIP_W  = 15;
    localparam int DPROD_W   = 29;
    localparam int SHIFT_10   = 18;
    localparam int SHIFT_100  = 21;
    localparam int SHIFT_1000 = 24;

    localparam logic [RECIP_W-1:0] RECIP_DEC =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd215) / 64'd216);
    localparam logic [RECIP_W-1:0] RECIP_BEAT =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd431) / 64'd432);
    localparam logic [RECIP_W-1:0] RECIP_HEX =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd674) / 64'd675);

    localparam logic [DRECIP_W-1:0] RECIP_10 =
        DRECIP_W'(((64'd1 << SHIFT_10) + 64'd9) / 64'd10);
    localparam logic [DRECIP_W-1:0] RECIP_100 =
        DRECIP_W'(((64'd1 << SHIFT_100) + 64'd99) / 64'd100);
    localparam logic [DRECIP_W-1:0] RECIP_1000 =
        DRECIP_W'(((64'd1 << SHIFT_1000) + 64'd999) / 64'd1000);

    localparam logic [SHIFT_W-1:0] HOUR_BIAS  = 7'd23;
    localparam logic [SHIFT_W-1:0] HOURS_DAY  = 7'd24;
    localparam logic [SHIFT_W-1:0] HOURS_2DAY = 7'd48;
    localparam logic [TOD_W-1:0]   SECS_HOUR  = 17'd3600;
    localparam logic [TOD_W-1:0]   DST_WRAP   = 17'd82800;
    localparam logic [NUM_W-1:0]   SCALE_DEC  = 23'd25;
    localparam logic [NUM_W-1:0]   SCALE_BEAT = 23'd5;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_F     = 7'h46;
    localparam logic [CHAR_W-1:0] CHAR_O     = 7'h4F;

    typedef struct packed {
        mode_t                 mode;
        logic                  dst_on;
        logic [HSEL_W-1:0]     hour_sel;
        logic [MINSEC_W-1:0]   minsec;
        logic [BLOCK_W-1:0]    block;
    } s1_t;

    typedef struct packed {
        mode_t                 mode;
        logic                  dst_on;
        logic [TOD_W-1:0]      tod;
        logic [BLOCK_W-1:0]    block;
    } s2_t;

    typedef struct packed {
        mode_t                 mode;
        logic [BLOCK_W-1:0]    block;
        logic [NUM_W-1:0]      num;
        logic [RECIP_W-1:0]    recip;
    } front_t;

    typedef struct packed {
        mode_t                 mode;
        logic [BLOCK_W-1:0]    block;
        logic [PROD_W-1:0]     prod;
    } s4_t;

    typedef struct packed {
        mode_t                 mode;
        logic [Q_W-1:0]        q;
        logic [HEX_W-1:0]      hex_val;
    } div_t;

    typedef struct packed {
        mode_t                 mode;
        logic [Q_W-1:0]        q;
        logic [Q10_W-1:0]      q10;
        logic [Q100_W-1:0]     q100;
        logic [Q1000_W-1:0]    q1000;
        logic [HEX_W-1:0]      hex_val;
    } s6_t;

    function automatic logic [CHAR_W-1:0] dec_char(input logic [3:0] d);
        return CHAR_ZERO + {3'b000, d};
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {3'b000, d};
        end
        else
        begin
            c = CHAR_A + {3'b000, d - 4'd10};
        end
        return c;
    endfunction

endpackage

>>> design/tdm_ifs.sv
`timescale 1ns / 1ps

interface tdm_time_if;
    logic                          valid;
    logic                          ready;
    logic [tdm_pkg::HOUR_W-1:0]    hour;
    logic [tdm_pkg::MIN_W-1:0]     minute;
    logic [tdm_pkg::SEC_W-1:0]     second;
    logic                          dst_active;

    modport source (output valid, hour, minute, second, dst_active, input ready);
    modport sink   (input valid, hour, minute, second, dst_active, output ready);
endinterface

interface tdm_disp_if;
    logic                          valid;
    logic                          ready;
    logic [tdm_pkg::CHAR_W-1:0]    char0;
    logic [tdm_pkg::CHAR_W-1:0]    char1;
    logic [tdm_pkg::CHAR_W-1:0]    char2;
    logic [tdm_pkg::CHAR_W-1:0]    char3;

    modport source (output valid, char0, char1, char2, char3, input ready);
    modport sink   (input valid, char0, char1, char2, char3, output ready);
endinterface

>>> design/tdm_front.sv
`timescale 1ns / 1ps

module tdm_front (
    input  logic                             clk,
    input  logic [2:0]                       load,
    input  tdm_pkg::mode_t                   cfg_mode,
    input  logic [tdm_pkg::OFFSET_W-1:0]     cfg_gmt_offset,
    input  logic                             cfg_dst_enable,
    input  logic [tdm_pkg::HOUR_W-1:0]       hour,
    input  logic [tdm_pkg::MIN_W-1:0]        minute,
    input  logic [tdm_pkg::SEC_W-1:0]        second,
    input  logic                             dst_active,
    output tdm_pkg::front_t                  front_out
);

    tdm_pkg::s1_t    s1_reg, s1_next;
    tdm_pkg::s2_t    s2_reg, s2_next;
    tdm_pkg::front_t s3_reg, s3_next;

    logic [tdm_pkg::SHIFT_W-1:0]  h_shift;
    logic [tdm_pkg::SHIFT_W-1:0]  h_wrap;
    logic [8:0]                   h_times11;
    logic [tdm_pkg::BLOCK_W-1:0]  block;
    logic [tdm_pkg::HOUR_W-1:0]   three_block;
    logic [tdm_pkg::HOUR_W-1:0]   hour_rem;
    logic [tdm_pkg::TOD_W-1:0]    tod_adj;

    // stage 1: hour selection per mode, minute and second weight
    always_comb
    begin
        h_shift = tdm_pkg::SHIFT_W'(hour) + tdm_pkg::HOUR_BIAS
                  - {{(tdm_pkg::SHIFT_W - tdm_pkg::OFFSET_W){cfg_gmt_offset[4]}},
                     cfg_gmt_offset};
        if (h_shift >= tdm_pkg::HOURS_2DAY)
        begin
            h_wrap = h_shift - tdm_pkg::HOURS_2DAY;
        end
        else if (h_shift >= tdm_pkg::HOURS_DAY)
        begin
            h_wrap = h_shift - tdm_pkg::HOURS_DAY;
        end
        else
        begin
            h_wrap = h_shift;
        end

        // hour / 3 for hours below 32
        h_times11   = {4'b0000, hour} * 9'd11;
        block       = h_times11[8:5];
        three_block = tdm_pkg::HOUR_W'({1'b0, block} + {block, 1'b0});
        hour_rem    = hour - three_block;

        s1_next.mode   = cfg_mode;
        s1_next.block  = block;
        s1_next.dst_on = cfg_dst_enable & dst_active & (cfg_mode == tdm_pkg::MODE_BEAT);
        s1_next.minsec = {minute, 6'b000000} - {4'b0000, minute, 2'b00}
                         + tdm_pkg::MINSEC_W'(second);
        unique case (cfg_mode)
            tdm_pkg::MODE_DEC:   s1_next.hour_sel = hour;
            tdm_pkg::MODE_BEAT:  s1_next.hour_sel = h_wrap[tdm_pkg::HSEL_W-1:0];
            tdm_pkg::MODE_HEX:   s1_next.hour_sel = hour_rem;
            tdm_pkg::MODE_BLANK: s1_next.hour_sel = '0;
        endcase
    end

    // stage 2: seconds of the day
    always_comb
    begin
        s2_next.mode   = s1_reg.mode;
        s2_next.dst_on = s1_reg.dst_on;
        s2_next.block  = s1_reg.block;
        s2_next.tod    = tdm_pkg::TOD_W'(s1_reg.hour_sel) * tdm_pkg::SECS_HOUR
                         + tdm_pkg::TOD_W'(s1_reg.minsec);
    end

    // stage 3: daylight hour, scale numerator and reciprocal select
    always_comb
    begin
        if (!s2_reg.dst_on)
        begin
            tod_adj = s2_reg.tod;
        end
        else if (s2_reg.tod < tdm_pkg::SECS_HOUR)
        begin
            tod_adj = s2_reg.tod + tdm_pkg::DST_WRAP;
        end
        else
        begin
            tod_adj = s2_reg.tod - tdm_pkg::SECS_HOUR;
        end

        s3_next.mode  = s2_reg.mode;
        s3_next.block = s2_reg.block;
        unique case (s2_reg.mode)
            tdm_pkg::MODE_DEC:
            begin
                s3_next.num   = tdm_pkg::NUM_W'(tod_adj) * tdm_pkg::SCALE_DEC;
                s3_next.recip = tdm_pkg::RECIP_DEC;
            end
            tdm_pkg::MODE_BEAT:
            begin
                s3_next.num   = tdm_pkg::NUM_W'(tod_adj) * tdm_pkg::SCALE_BEAT;
                s3_next.recip = tdm_pkg::RECIP_BEAT;
            end
            tdm_pkg::MODE_HEX:
            begin
                s3_next.num   = tdm_pkg::NUM_W'({tod_adj, 9'b000000000});
                s3_next.recip = tdm_pkg::RECIP_HEX;
            end
            tdm_pkg::MODE_BLANK:
            begin
                s3_next.num   = '0;
                s3_next.recip = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_reg <= s1_next;
        end
        if (load[1])
        begin
            s2_reg <= s2_next;
        end
        if (load[2])
        begin
            s3_reg <= s3_next;
        end
    end

    assign front_out = s3_reg;

endmodule

>>> design/tdm_div.sv
`timescale 1ns / 1ps

module tdm_div (
    input  logic            clk,
    input  logic [1:0]      load,
    input  tdm_pkg::front_t div_in,
    output tdm_pkg::div_t   div_out
);

    tdm_pkg::s4_t  s4_reg, s4_next;
    tdm_pkg::div_t s5_reg, s5_next;

    logic [tdm_pkg::Q_W-1:0] quot;

    // stage 4: reciprocal multiply
    always_comb
    begin
        s4_next.mode  = div_in.mode;
        s4_next.block = div_in.block;
        s4_next.prod  = tdm_pkg::PROD_W'(div_in.num) * tdm_pkg::PROD_W'(div_in.recip);
    end

    // stage 5: quotient and hex block offset
    always_comb
    begin
        quot            = s4_reg.prod[tdm_pkg::DIV_SHIFT +: tdm_pkg::Q_W];
        s5_next.mode    = s4_reg.mode;
        s5_next.q       = quot;
        s5_next.hex_val = tdm_pkg::HEX_W'(quot) + {s4_reg.block[2:0], 13'd0};
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s4_reg <= s4_next;
        end
        if (load[1])
        begin
            s5_reg <= s5_next;
        end
    end

    assign div_out = s5_reg;

endmodule

>>> design/tdm_digits.sv
`timescale 1ns / 1ps

module tdm_digits (
    input  logic                         clk,
    input  logic [1:0]                   load,
    input  tdm_pkg::div_t                dig_in,
    output logic [tdm_pkg::CHAR_W-1:0]   char0,
    output logic [tdm_pkg::CHAR_W-1:0]   char1,
    output logic [tdm_pkg::CHAR_W-1:0]   char2,
    output logic [tdm_pkg::CHAR_W-1:0]   char3
);

    tdm_pkg::s6_t s6_reg, s6_next;

    logic [tdm_pkg::DPROD_W-1:0] prod10;
    logic [tdm_pkg::DPROD_W-1:0] prod100;
    logic [tdm_pkg::DPROD_W-1:0] prod1000;

    logic [tdm_pkg::Q_W-1:0]     diff0;
    logic [tdm_pkg::Q10_W-1:0]   diff1;
    logic [tdm_pkg::Q100_W-1:0]  diff2;
    logic [3:0]                  d0, d1, d2, d3;

    logic [tdm_pkg::CHAR_W-1:0]  char0_reg, char0_next;
    logic [tdm_pkg::CHAR_W-1:0]  char1_reg, char1_next;
    logic [tdm_pkg::CHAR_W-1:0]  char2_reg, char2_next;
    logic [tdm_pkg::CHAR_W-1:0]  char3_reg, char3_next;

    // stage 6: quotients by 10, 100 and 1000
    always_comb
    begin
        prod10   = tdm_pkg::DPROD_W'(dig_in.q) * tdm_pkg::DPROD_W'(tdm_pkg::RECIP_10);
        prod100  = tdm_pkg::DPROD_W'(dig_in.q) * tdm_pkg::DPROD_W'(tdm_pkg::RECIP_100);
        prod1000 = tdm_pkg::DPROD_W'(dig_in.q) * tdm_pkg::DPROD_W'(tdm_pkg::RECIP_1000);

        s6_next.mode    = dig_in.mode;
        s6_next.q       = dig_in.q;
        s6_next.hex_val = dig_in.hex_val;
        s6_next.q10     = prod10[tdm_pkg::SHIFT_10 +: tdm_pkg::Q10_W];
        s6_next.q100    = prod100[tdm_pkg::SHIFT_100 +: tdm_pkg::Q100_W];
        s6_next.q1000   = prod1000[tdm_pkg::SHIFT_1000 +: tdm_pkg::Q1000_W];
    end

    // stage 7: digits and characters
    always_comb
    begin
        diff0 = s6_reg.q - (tdm_pkg::Q_W'({s6_reg.q10, 3'b000})
                            + tdm_pkg::Q_W'({s6_reg.q10, 1'b0}));
        diff1 = s6_reg.q10 - (tdm_pkg::Q10_W'({s6_reg.q100, 3'b000})
                              + tdm_pkg::Q10_W'({s6_reg.q100, 1'b0}));
        diff2 = s6_reg.q100 - (tdm_pkg::Q100_W'({s6_reg.q1000, 3'b000})
                               + tdm_pkg::Q100_W'({s6_reg.q1000, 1'b0}));
        d0 = diff0[3:0];
        d1 = diff1[3:0];
        d2 = diff2[3:0];
        d3 = (s6_reg.q1000 >= 4'd10) ? s6_reg.q1000 - 4'd10 : s6_reg.q1000;

        unique case (s6_reg.mode)
            tdm_pkg::MODE_DEC:
            begin
                char0_next = tdm_pkg::dec_char(d3);
                char1_next = tdm_pkg::dec_char(d2);
                char2_next = tdm_pkg::dec_char(d1);
                char3_next = tdm_pkg::dec_char(d0);
            end
            tdm_pkg::MODE_BEAT:
            begin
                char0_next = tdm_pkg::CHAR_O;
                char1_next = tdm_pkg::dec_char(d2);
                char2_next = tdm_pkg::dec_char(d1);
                char3_next = tdm_pkg::dec_char(d0);
            end
            tdm_pkg::MODE_HEX:
            begin
                char0_next = tdm_pkg::hex_char(s6_reg.hex_val[15:12]);
                char1_next = tdm_pkg::hex_char(s6_reg.hex_val[11:8]);
                char2_next = tdm_pkg::hex_char(s6_reg.hex_val[7:4]);
                char3_next = tdm_pkg::hex_char(s6_reg.hex_val[3:0]);
            end
            tdm_pkg::MODE_BLANK:
            begin
                char0_next = tdm_pkg::CHAR_SPACE;
                char1_next = tdm_pkg::CHAR_SPACE;
                char2_next = tdm_pkg::CHAR_SPACE;
                char3_next = tdm_pkg::CHAR_SPACE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s6_reg <= s6_next;
        end
        if (load[1])
        begin
            char0_reg <= char0_next;
            char1_reg <= char1_next;
            char2_reg <= char2_next;
            char3_reg <= char3_next;
        end
    end

    assign char0 = char0_reg;
    assign char1 = char1_reg;
    assign char2 = char2_reg;
    assign char3 = char3_reg;

endmodule

>>> design/time_of_day_to_metric_digits.sv
// throughput: one transaction per cycle while disp_ch is not stalled; seven register stages,
// the 23x26 reciprocal multiply and the digit split each own a stage
// per-stage valid bits let bubbles close up while the output is stalled
// reset clears all valid bits and sets mode, gmt_offset and dst_enable to zero
`timescale 1ns / 1ps

module time_of_day_to_metric_digits (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tdm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tdm_pkg::CFG_DATA_W-1:0]      cfg_data,
    tdm_time_if.sink                            time_ch,
    tdm_disp_if.source                          disp_ch
);

    localparam int LAST = tdm_pkg::NUM_STAGES - 1;

    tdm_pkg::mode_t                  mode_reg;
    logic [tdm_pkg::OFFSET_W-1:0]    gmt_offset_reg;
    logic                            dst_enable_reg;

    logic [tdm_pkg::NUM_STAGES-1:0]  valid_reg, valid_next;
    logic [tdm_pkg::NUM_STAGES-1:0]  stage_rdy;
    logic [tdm_pkg::NUM_STAGES-1:0]  stage_load;
    logic [tdm_pkg::NUM_STAGES-1:0]  upstream_valid;

    tdm_pkg::front_t                 front_data;
    tdm_pkg::div_t                   div_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= tdm_pkg::MODE_DEC;
            gmt_offset_reg <= '0;
            dst_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tdm_pkg::CFG_MODE:       mode_reg       <= tdm_pkg::mode_t'(cfg_data[1:0]);
                tdm_pkg::CFG_GMT_OFFSET: gmt_offset_reg <= cfg_data[tdm_pkg::OFFSET_W-1:0];
                tdm_pkg::CFG_DST_ENABLE: dst_enable_reg <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        upstream_valid = {valid_reg[LAST-1:0], time_ch.valid};
        stage_rdy[LAST] = !valid_reg[LAST] || disp_ch.ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
        valid_next = valid_reg;
        for (int i = 0; i < tdm_pkg::NUM_STAGES; i++)
        begin
            stage_load[i] = upstream_valid[i] && stage_rdy[i];
            if (stage_rdy[i])
            begin
                valid_next[i] = upstream_valid[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    tdm_front u_front (
        .clk            (clk),
        .load           (stage_load[2:0]),
        .cfg_mode       (mode_reg),
        .cfg_gmt_offset (gmt_offset_reg),
        .cfg_dst_enable (dst_enable_reg),
        .hour           (time_ch.hour),
        .minute         (time_ch.minute),
        .second         (time_ch.second),
        .dst_active     (time_ch.dst_active),
        .front_out      (front_data)
    );

    tdm_div u_div (
        .clk     (clk),
        .load    (stage_load[4:3]),
        .div_in  (front_data),
        .div_out (div_data)
    );

    tdm_digits u_digits (
        .clk    (clk),
        .load   (stage_load[6:5]),
        .dig_in (div_data),
        .char0  (disp_ch.char0),
        .char1  (disp_ch.char1),
        .char2  (disp_ch.char2),
        .char3  (disp_ch.char3)
    );

    assign time_ch.ready = stage_rdy[0];
    assign disp_ch.valid = valid_reg[LAST];

endmodule

>>> design/tdm_checker.sv
`timescale 1ns / 1ps

module tdm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [tdm_pkg::CHAR_W-1:0]    char0,
    input logic [tdm_pkg::CHAR_W-1:0]    char1,
    input logic [tdm_pkg::CHAR_W-1:0]    char2,
    input logic [tdm_pkg::CHAR_W-1:0]    char3
);

    // backpressure reaches the input only through a stalled output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a stalled output");

    a_lead_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((char0 >= tdm_pkg::CHAR_ZERO && char0 <= tdm_pkg::CHAR_NINE)
                    || (char0 >= tdm_pkg::CHAR_A && char0 <= tdm_pkg::CHAR_F)
                    || char0 == tdm_pkg::CHAR_O || char0 == tdm_pkg::CHAR_SPACE))
        else $error("leading character outside the display set");

    // blank mode fills every position, other modes none
    a_blank_all: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((char0 == tdm_pkg::CHAR_SPACE) == (char3 == tdm_pkg::CHAR_SPACE))
                   && ((char1 == tdm_pkg::CHAR_SPACE) == (char2 == tdm_pkg::CHAR_SPACE))
                   && ((char0 == tdm_pkg::CHAR_SPACE) == (char1 == tdm_pkg::CHAR_SPACE)))
        else $error("partial blank result");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(char0) && $stable(char1)
                                     && $stable(char2) && $stable(char3)))
        else $error("result changed while stalled");

endmodule

bind time_of_day_to_metric_digits tdm_checker u_tdm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (time_ch.ready),
    .out_valid (disp_ch.valid),
    .out_ready (disp_ch.ready),
    .char0     (disp_ch.char0),
    .char1     (disp_ch.char1),
    .char2     (disp_ch.char2),
    .char3     (disp_ch.char3)
);
